/* rtl/wcmp_pkg.sv */
// shared constants, types and channel arithmetic for the weighted colour projection
`default_nettype none

package wcmp_pkg;

	localparam int DEF_MAX_WIDTH  = 512;
	localparam int DEF_MAX_HEIGHT = 512;

	localparam int CFG_ADDR_W = 3;
	localparam int CFG_DATA_W = 10;
	localparam int DIM_W      = 10;
	localparam int WEIGHT_W   = 9;
	localparam int CHAN_W     = 8;
	localparam int PIX_W      = 3 * CHAN_W;

	localparam int OUT_FIFO_DEPTH = 4;

	localparam logic [CFG_ADDR_W-1:0] REG_FRAME_WIDTH  = 3'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 3'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_RED_WEIGHT   = 3'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_GREEN_WEIGHT = 3'd3;
	localparam logic [CFG_ADDR_W-1:0] REG_BLUE_WEIGHT  = 3'd4;

	localparam logic [DIM_W-1:0]    RST_FRAME_WIDTH  = 10'd512;
	localparam logic [DIM_W-1:0]    RST_FRAME_HEIGHT = 10'd512;
	localparam logic [WEIGHT_W-1:0] RST_WEIGHT       = 9'd256;

	typedef enum logic [1:0] {
		REQ_ACCUM   = 2'd0,
		REQ_READ    = 2'd1,
		REQ_RESTART = 2'd2
	} req_type_t;

	// voxel times q1.8 weight, truncated, saturated at full scale
	function automatic logic [CHAN_W-1:0] scale_channel(input logic [CHAN_W-1:0] vox,
		input logic [WEIGHT_W-1:0] w);
		logic [CHAN_W+WEIGHT_W-1:0] prod;
		prod = (CHAN_W+WEIGHT_W)'(vox) * (CHAN_W+WEIGHT_W)'(w);
		return prod[CHAN_W+WEIGHT_W-1] ? {CHAN_W{1'b1}} : prod[CHAN_W+WEIGHT_W-2:CHAN_W];
	endfunction

	function automatic logic [CHAN_W-1:0] max_chan(input logic [CHAN_W-1:0] a,
		input logic [CHAN_W-1:0] b);
		return (a > b) ? a : b;
	endfunction

endpackage

`default_nettype wire

/* rtl/wcmp_ram.sv */
// generic single-write, single-read ram with registered read data
`default_nettype none

module wcmp_ram #(
	parameter int WIDTH = 24,
	parameter int DEPTH = 1024,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  wire logic             clk,
	input  wire logic             wr_en,
	input  wire logic [AW-1:0]    wr_addr,
	input  wire logic [WIDTH-1:0] wr_data,
	input  wire logic [AW-1:0]    rd_addr,
	output logic      [WIDTH-1:0] rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end

endmodule

`default_nettype wire

/* rtl/weighted_color_max_projection.sv */
// weighted colour maximum intensity projection: top level with frame store and result queue
// a request's result passes the stage 1 registers, then the result queue, before it shows on m_tvalid
// throughput: one request per cycle while s_tready is high, using the frame store's read port and write port
// a write of a pixel is forwarded to a read of the same pixel issued in the same cycle
// reset: registers take their reset values at once, then the frame store is zeroed one pixel
// a cycle, with s_tready low until every pixel of the store is clear
`default_nettype none

module weighted_color_max_projection #(
	parameter int MAX_WIDTH  = wcmp_pkg::DEF_MAX_WIDTH,
	parameter int MAX_HEIGHT = wcmp_pkg::DEF_MAX_HEIGHT
) (
	input  wire logic                                 clk,
	input  wire logic                                 arst_n,
	input  wire logic                                 cfg_wr_en,
	input  wire logic [wcmp_pkg::CFG_ADDR_W-1:0]      cfg_addr,
	input  wire logic [wcmp_pkg::CFG_DATA_W-1:0]      cfg_wdata,
	input  wire logic                                 s_tvalid,
	output logic                                      s_tready,
	// voxel [7:0], read_column [16:8], read_row [25:17], zero fill above
	input  wire logic [31:0]                          s_tdata,
	// req_type [1:0]
	input  wire logic [1:0]                           s_tuser,
	output logic                                      m_tvalid,
	input  wire logic                                 m_tready,
	// red [7:0], green [15:8], blue [23:16]
	output logic [wcmp_pkg::PIX_W-1:0]                m_tdata,
	// slice_done
	output logic                                      m_tlast
);

	localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
	localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW    = $clog2(MAX_WIDTH + 1);
	localparam int RW    = $clog2(MAX_HEIGHT + 1);
	localparam int CH    = wcmp_pkg::CHAN_W;
	localparam int PW    = wcmp_pkg::PIX_W;
	localparam int QD    = wcmp_pkg::OUT_FIFO_DEPTH;
	localparam int QPW   = $clog2(QD);
	localparam int QCW   = QPW + 1;

	// configuration
	logic [wcmp_pkg::DIM_W-1:0]    frame_width_q, frame_height_q;
	logic [wcmp_pkg::WEIGHT_W-1:0] red_weight_q, green_weight_q, blue_weight_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frame_width_q  <= wcmp_pkg::RST_FRAME_WIDTH;
			frame_height_q <= wcmp_pkg::RST_FRAME_HEIGHT;
			red_weight_q   <= wcmp_pkg::RST_WEIGHT;
			green_weight_q <= wcmp_pkg::RST_WEIGHT;
			blue_weight_q  <= wcmp_pkg::RST_WEIGHT;
		end else if (cfg_wr_en) begin
			unique case (cfg_addr)
				wcmp_pkg::REG_FRAME_WIDTH:  frame_width_q  <= cfg_wdata;
				wcmp_pkg::REG_FRAME_HEIGHT: frame_height_q <= cfg_wdata;
				wcmp_pkg::REG_RED_WEIGHT:   red_weight_q   <= cfg_wdata[wcmp_pkg::WEIGHT_W-1:0];
				wcmp_pkg::REG_GREEN_WEIGHT: green_weight_q <= cfg_wdata[wcmp_pkg::WEIGHT_W-1:0];
				wcmp_pkg::REG_BLUE_WEIGHT:  blue_weight_q  <= cfg_wdata[wcmp_pkg::WEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	// effective frame size: zero counts as one, above the store counts as the store size
	logic [CW-1:0] width_eff;
	logic [RW-1:0] height_eff;

	always_comb begin
		if (frame_width_q == '0) begin
			width_eff = CW'(1);
		end else if (32'(frame_width_q) > MAX_WIDTH) begin
			width_eff = CW'(MAX_WIDTH);
		end else begin
			width_eff = CW'(frame_width_q);
		end
		if (frame_height_q == '0) begin
			height_eff = RW'(1);
		end else if (32'(frame_height_q) > MAX_HEIGHT) begin
			height_eff = RW'(MAX_HEIGHT);
		end else begin
			height_eff = RW'(frame_height_q);
		end
	end

	// request decode
	wcmp_pkg::req_type_t in_req;
	logic [CH-1:0] in_voxel;
	logic [8:0]    in_col, in_row;
	logic          accept;

	assign in_req   = wcmp_pkg::req_type_t'(s_tuser);
	assign in_voxel = s_tdata[7:0];
	assign in_col   = s_tdata[16:8];
	assign in_row   = s_tdata[25:17];
	assign accept   = s_tvalid & s_tready;

	// scan position
	logic [CW-1:0] col_q, col_inc;
	logic [RW-1:0] row_q, row_inc;
	logic          row_wrap, col_wrap;

	assign row_inc  = row_q + RW'(1);
	assign col_inc  = col_q + CW'(1);
	assign row_wrap = row_inc >= height_eff;
	assign col_wrap = col_inc >= width_eff;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			col_q <= '0;
		end else if (accept) begin
			unique case (in_req)
				wcmp_pkg::REQ_ACCUM: begin
					if (row_wrap) begin
						row_q <= '0;
						col_q <= col_wrap ? '0 : col_inc;
					end else begin
						row_q <= row_inc;
					end
				end
				wcmp_pkg::REQ_RESTART: begin
					row_q <= '0;
					col_q <= '0;
				end
				default: ;
			endcase
		end
	end

	// store addresses
	logic [AW-1:0] acc_addr, rd_addr, ram_raddr;
	logic          rd_in_range;

	assign acc_addr    = AW'(32'(row_q) * MAX_WIDTH + 32'(col_q));
	assign rd_addr     = AW'(32'(in_row) * MAX_WIDTH + 32'(in_col));
	assign rd_in_range = (32'(in_col) < MAX_WIDTH) && (32'(in_row) < MAX_HEIGHT);
	assign ram_raddr   = (in_req == wcmp_pkg::REQ_READ) ? rd_addr : acc_addr;

	// stage 1: store data arrives
	logic                valid_s1;
	wcmp_pkg::req_type_t req_s1;
	logic [AW-1:0]       addr_s1;
	logic                zero_s1, done_s1;
	logic [CH-1:0]       red_s1, green_s1, blue_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			req_s1   <= in_req;
			addr_s1  <= ram_raddr;
			zero_s1  <= !rd_in_range;
			done_s1  <= row_wrap && col_wrap;
			red_s1   <= wcmp_pkg::scale_channel(in_voxel, red_weight_q);
			green_s1 <= wcmp_pkg::scale_channel(in_voxel, green_weight_q);
			blue_s1  <= wcmp_pkg::scale_channel(in_voxel, blue_weight_q);
		end
	end

	// frame store and clearing pass
	logic          clearing_q;
	logic [AW-1:0] clr_addr_q;
	logic [PW-1:0] ram_rdata;
	logic          ram_we;
	logic [AW-1:0] ram_waddr;
	logic [PW-1:0] ram_wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clearing_q <= 1'b1;
			clr_addr_q <= '0;
		end else if (clearing_q) begin
			clr_addr_q <= clr_addr_q + AW'(1);
			if (clr_addr_q == AW'(DEPTH - 1)) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// last write, forwarded to a read of the same pixel issued alongside it
	logic          wr_valid_q;
	logic [AW-1:0] wr_addr_q;
	logic [PW-1:0] wr_data_q;
	logic [PW-1:0] base_pix, new_pix;
	logic          acc_we;

	assign base_pix = (wr_valid_q && (wr_addr_q == addr_s1)) ? wr_data_q : ram_rdata;
	assign new_pix  = {wcmp_pkg::max_chan(red_s1,   base_pix[3*CH-1:2*CH]),
	                   wcmp_pkg::max_chan(green_s1, base_pix[2*CH-1:CH]),
	                   wcmp_pkg::max_chan(blue_s1,  base_pix[CH-1:0])};
	assign acc_we   = valid_s1 && (req_s1 == wcmp_pkg::REQ_ACCUM);

	assign ram_we    = clearing_q || acc_we;
	assign ram_waddr = clearing_q ? clr_addr_q : addr_s1;
	assign ram_wdata = clearing_q ? '0 : new_pix;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_valid_q <= 1'b0;
		end else begin
			wr_valid_q <= acc_we;
		end
	end

	always_ff @(posedge clk) begin
		wr_addr_q <= addr_s1;
		wr_data_q <= new_pix;
	end

	wcmp_ram #(
		.WIDTH (PW),
		.DEPTH (DEPTH)
	) u_frame_store (
		.clk     (clk),
		.wr_en   (ram_we),
		.wr_addr (ram_waddr),
		.wr_data (ram_wdata),
		.rd_addr (ram_raddr),
		.rd_data (ram_rdata)
	);

	// result formatting: red lowest on the stream
	logic [PW:0] result_s1;

	always_comb begin
		result_s1 = '0;
		unique case (req_s1)
			wcmp_pkg::REQ_ACCUM: begin
				result_s1 = {done_s1, new_pix[CH-1:0], new_pix[2*CH-1:CH], new_pix[3*CH-1:2*CH]};
			end
			wcmp_pkg::REQ_READ: begin
				if (!zero_s1) begin
					result_s1 = {1'b0, base_pix[CH-1:0], base_pix[2*CH-1:CH],
					             base_pix[3*CH-1:2*CH]};
				end
			end
			default: ;
		endcase
	end

	// result queue: room for every request in flight, so stage 1 never stalls
	logic [PW:0]    queue_q [QD];
	logic [QPW-1:0] q_wr_ptr_q, q_rd_ptr_q;
	logic [QCW-1:0] q_count_q;
	logic           q_pop;

	assign q_pop    = m_tvalid & m_tready;
	assign m_tvalid = q_count_q != '0;
	assign {m_tlast, m_tdata} = queue_q[q_rd_ptr_q];
	assign s_tready = !clearing_q &&
		(({1'b0, q_count_q} + (QCW+1)'(valid_s1)) < (QCW+1)'(QD));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			q_wr_ptr_q <= '0;
			q_rd_ptr_q <= '0;
			q_count_q  <= '0;
		end else begin
			if (valid_s1) begin
				q_wr_ptr_q <= q_wr_ptr_q + QPW'(1);
			end
			if (q_pop) begin
				q_rd_ptr_q <= q_rd_ptr_q + QPW'(1);
			end
			unique case ({valid_s1, q_pop})
				2'b10:   q_count_q <= q_count_q + QCW'(1);
				2'b01:   q_count_q <= q_count_q - QCW'(1);
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (valid_s1) begin
			queue_q[q_wr_ptr_q] <= result_s1;
		end
	end

endmodule

`default_nettype wire
